// ===== design/stk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Segment top-k selector package
// Shared field widths, payload structures, controller states and the
// command and status bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package stk_pkg;

    // Fixed field widths of the transfer payloads.
    localparam int SCORE_BITS    = 16;
    localparam int POSITION_BITS = 20;
    localparam int KEEP_BITS     = 5;

    // Reset value of the keep count register.
    localparam logic [KEEP_BITS-1:0] KEEP_RESET = KEEP_BITS'(8);

    // One score entry of a row.
    typedef struct packed {
        logic signed [SCORE_BITS-1:0] score;
        logic [POSITION_BITS-1:0]     position;
        logic                         row_last;
    } t_in_item;

    // One reported entry.
    typedef struct packed {
        logic [POSITION_BITS-1:0]     best_position;
        logic signed [SCORE_BITS-1:0] top_score;
        logic                         run_last;
    } t_out_item;

    // Controller states.
    typedef enum logic {
        ST_ACCEPT,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic pop;
        logic pop_last;
    } t_dp_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage : stk_pkg
`default_nettype wire

// ===== design/stk_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Segment top-k selector datapath
// Sorted list of kept entries with parallel compare-and-shift insertion,
// pop towards the head for emission, fill count and output register.
// ----------------------------------------------------------------------------
module stk_datapath
    import stk_pkg::*;
#(
    parameter int KEEP_MAX = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire t_in_item                         i_in_data,
    input  wire t_dp_ctl                          i_ctl,
    input  wire logic                             i_out_stall,
    output t_dp_stat                              o_stat,
    output logic [$clog2(KEEP_MAX + 1)-1:0]       o_fill_next,
    output logic                                  o_out_valid,
    output t_out_item                             o_out_data
);

    localparam int CNT_W = $clog2(KEEP_MAX + 1);

    // Kept entries, best first.
    logic signed [SCORE_BITS-1:0] r_score [KEEP_MAX];
    logic [POSITION_BITS-1:0]     r_pos   [KEEP_MAX];
    logic signed [SCORE_BITS-1:0] n_score [KEEP_MAX];
    logic [POSITION_BITS-1:0]     n_pos   [KEEP_MAX];
    logic [CNT_W-1:0]             r_fill;
    logic [CNT_W-1:0]             n_fill;
    logic                         r_out_valid;
    logic                         n_out_valid;
    t_out_item                    r_out;
    t_out_item                    n_out;

    // An entry is displaced when the new one ranks above it or it is unused.
    logic [KEEP_MAX-1:0] gt;
    logic [KEEP_MAX-1:0] take;

    genvar g;
    generate
        for (g = 0; g < KEEP_MAX; g++) begin : g_cell
            // Rank compare: higher score first, then lower position.
            always_comb begin
                gt[g] = (CNT_W'(g) < r_fill) &&
                        ((i_in_data.score > r_score[g]) ||
                         ((i_in_data.score == r_score[g]) &&
                          (i_in_data.position < r_pos[g])));
                take[g] = gt[g] || !(CNT_W'(g) < r_fill);
            end

            // Next value of this cell: insert, shift down, pop or hold.
            if (g == 0) begin : g_head
                always_comb begin
                    n_score[g] = r_score[g];
                    n_pos[g]   = r_pos[g];
                    if (i_ctl.accept && take[g]) begin
                        n_score[g] = i_in_data.score;
                        n_pos[g]   = i_in_data.position;
                    end else if (i_ctl.pop && (KEEP_MAX > 1)) begin
                        n_score[g] = r_score[(KEEP_MAX > 1) ? g + 1 : g];
                        n_pos[g]   = r_pos[(KEEP_MAX > 1) ? g + 1 : g];
                    end
                end
            end else begin : g_body
                always_comb begin
                    n_score[g] = r_score[g];
                    n_pos[g]   = r_pos[g];
                    if (i_ctl.accept && take[g]) begin
                        if (!take[g-1]) begin
                            n_score[g] = i_in_data.score;
                            n_pos[g]   = i_in_data.position;
                        end else begin
                            n_score[g] = r_score[g-1];
                            n_pos[g]   = r_pos[g-1];
                        end
                    end else if (i_ctl.pop && (g < KEEP_MAX - 1)) begin
                        n_score[g] = r_score[(g < KEEP_MAX - 1) ? g + 1 : g];
                        n_pos[g]   = r_pos[(g < KEEP_MAX - 1) ? g + 1 : g];
                    end
                end
            end
        end
    endgenerate

    // List payload registers.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < KEEP_MAX; i++) begin
            r_score[i] <= n_score[i];
            r_pos[i]   <= n_pos[i];
        end
    end

    // Fill count after an insertion; a full list stays full.
    assign o_fill_next = (r_fill == CNT_W'(KEEP_MAX)) ? r_fill : r_fill + CNT_W'(1);

    always_comb begin
        n_fill = r_fill;
        if (i_ctl.accept) begin
            n_fill = o_fill_next;
        end else if (i_ctl.pop_last) begin
            n_fill = '0;
        end
    end

    // Output register, loaded from the head of the list on each pop.
    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (i_ctl.pop) begin
            n_out.best_position = r_pos[0];
            n_out.top_score     = r_score[0];
            n_out.run_last      = i_ctl.pop_last;
            n_out_valid         = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

    // Checks on the list bookkeeping.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(KEEP_MAX))
        else $error("Fill count exceeds list depth.");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.pop |-> (r_fill != '0))
        else $error("Pop from an empty list.");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.pop_last |=> ((r_fill == '0) && r_out_valid && r_out.run_last))
        else $error("Final transfer of a row did not clear the list.");

endmodule : stk_datapath
`default_nettype wire

// ===== design/stk_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Segment top-k selector controller
// Holds the keep count register, sequences insertion and the emission of
// the kept entries at the end of each row.
// ----------------------------------------------------------------------------
module stk_ctrl
    import stk_pkg::*;
#(
    parameter int KEEP_MAX = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [KEEP_BITS-1:0]          i_cfg_data,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_row_last,
    input  wire t_dp_stat                      i_stat,
    input  wire logic [$clog2(KEEP_MAX + 1)-1:0] i_fill_next,
    output logic                               o_in_stall,
    output t_dp_ctl                            o_ctl
);

    localparam int CNT_W = $clog2(KEEP_MAX + 1);

    t_state                r_state;
    t_state                n_state;
    logic [CNT_W-1:0]      r_left;
    logic [CNT_W-1:0]      n_left;
    logic [KEEP_BITS-1:0]  r_keep;
    logic [KEEP_BITS-1:0]  keep_min;
    logic [CNT_W-1:0]      keep_eff;
    logic [CNT_W-1:0]      emit_count;

    // Keep count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep <= KEEP_RESET;
        end else if (i_cfg_we) begin
            r_keep <= i_cfg_data;
        end
    end

    // Effective keep count: zero reads as one, large values saturate.
    always_comb begin
        keep_min = (r_keep == '0) ? KEEP_BITS'(1) : r_keep;
        if (32'(keep_min) > 32'(KEEP_MAX)) begin
            keep_eff = CNT_W'(KEEP_MAX);
        end else begin
            keep_eff = CNT_W'(keep_min);
        end
        emit_count = (i_fill_next < keep_eff) ? i_fill_next : keep_eff;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_ACCEPT: begin
                if (i_in_valid && i_row_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free && (r_left == CNT_W'(1))) begin
                    n_state = ST_ACCEPT;
                end
            end
            default: begin
                n_state = ST_ACCEPT;
            end
        endcase
    end

    // Outputs to the datapath and the input channel.
    always_comb begin
        o_in_stall     = 1'b1;
        o_ctl.accept   = 1'b0;
        o_ctl.pop      = 1'b0;
        o_ctl.pop_last = 1'b0;
        unique case (r_state)
            ST_ACCEPT: begin
                o_in_stall   = 1'b0;
                o_ctl.accept = i_in_valid;
            end
            ST_EMIT: begin
                o_ctl.pop      = i_stat.out_free;
                o_ctl.pop_last = i_stat.out_free && (r_left == CNT_W'(1));
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // Remaining transfers of the current emission.
    always_comb begin
        n_left = r_left;
        if (o_ctl.accept && i_row_last) begin
            n_left = emit_count;
        end else if (o_ctl.pop) begin
            n_left = r_left - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACCEPT;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
        end
    end

    // Checks on the sequencing.
    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_left != '0))
        else $error("Emission running with nothing left to send.");

    a_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.accept && i_row_last) |=> ((r_state == ST_EMIT) && (r_left != '0)))
        else $error("Row end did not start an emission.");

    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.pop_last |=> ((r_state == ST_ACCEPT) && (r_left == '0)))
        else $error("Emission did not finish after its final transfer.");

endmodule : stk_ctrl
`default_nettype wire

// ===== design/segment_top_k_selector.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Segment top-k selector
// Keeps the best-scoring entries of each row and reports them best first.
// ----------------------------------------------------------------------------
// Usage:
// Score entries arrive on the input channel (valid/stall), one per transfer.
// Each is inserted into a sorted list of up to KEEP_MAX entries in the cycle
// of its transfer, so a row streams in at one entry per clock. Ranking is
// by higher score, then lower position.
// The entry marked row_last is inserted too; the block then stalls its input
// and sends min(fill, keep_count) results on the output channel, best first,
// one per cycle while the receiver does not stall, the last one flagged.
// The first result is presented once the controller has entered its emit
// state and the output register has been loaded from the head of the list.
// The input is stalled while the results of a row are sent. The output
// register lets a new row start while the final result is still waiting.
// A receiver stall holds the output register and pauses the emission.
// keep_count is written through i_cfg_we/i_cfg_data while idle; zero acts
// as one and values above KEEP_MAX saturate.
// Synchronous reset empties the list, drops any pending result and sets
// keep_count to eight.
// ----------------------------------------------------------------------------
module segment_top_k_selector
    import stk_pkg::*;
#(
    parameter int KEEP_MAX = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [KEEP_BITS-1:0]  i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_item                  o_out_data
);

    localparam int CNT_W = $clog2(KEEP_MAX + 1);

    t_dp_ctl          dp_ctl;
    t_dp_stat         dp_stat;
    logic [CNT_W-1:0] fill_next;

    // Sequencer and keep count register.
    stk_ctrl #(
        .KEEP_MAX (KEEP_MAX)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_row_last  (i_in_data.row_last),
        .i_stat      (dp_stat),
        .i_fill_next (fill_next),
        .o_in_stall  (o_in_stall),
        .o_ctl       (dp_ctl)
    );

    // Sorted list and output register.
    stk_datapath #(
        .KEEP_MAX (KEEP_MAX)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_ctl       (dp_ctl),
        .i_out_stall (i_out_stall),
        .o_stat      (dp_stat),
        .o_fill_next (fill_next),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule : segment_top_k_selector
`default_nettype wire

// ===== sim/segment_top_k_selector_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment top-k selector testbench
// Streams rows of scored entries into the selector and checks each reported
// entry against a local ranking of the row. The keep count is changed
// between phases, and both sides of the block idle and stall at random.
// ----------------------------------------------------------------------------
module segment_top_k_selector_test;
    import stk_pkg::*;

    localparam int KEEP_MAX       = 16;
    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 12;
    localparam int PHASE_ITEMS    = 40;
    localparam int PHASE_COUNT    = 9;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int SQUEEZE_CYCLES = 200;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef enum int {
        IDLE_RX_HEAVY,
        IDLE_TX_HEAVY,
        IDLE_NONE
    } t_idle_mode;

    typedef enum int {
        SCORE_WIDE,
        SCORE_MIXED,
        SCORE_NARROW,
        SCORE_EXTREME
    } t_score_style;

    typedef enum int {
        POS_WIDE,
        POS_NARROW,
        POS_HIGH
    } t_pos_style;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [KEEP_BITS-1:0] i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_data  = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_data;

    segment_top_k_selector #(
        .KEEP_MAX(KEEP_MAX)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    // Ranked list of the current row, best first, and the keep count in force.
    logic signed [SCORE_BITS-1:0] held_score [KEEP_MAX];
    logic [POSITION_BITS-1:0]     held_pos [KEEP_MAX];
    int                           held_count   = 0;
    logic [KEEP_BITS-1:0]         keep_setting = KEEP_RESET;

    t_in_item   entry_queue [$];
    t_out_item  pending_best [$];

    t_idle_mode idle_mode        = IDLE_RX_HEAVY;
    bit         squeeze_armed    = 1'b0;
    bit         squeeze_done     = 1'b0;
    int         squeeze_left     = 0;
    int         entries_queued   = 0;
    int         entries_accepted = 0;
    int         rows_closed      = 0;
    int         results_checked  = 0;
    int         quiet_cycles     = 0;
    int         errors           = 0;

    // Free-running clock.
    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    function automatic int sender_idle_pct();
        case (idle_mode)
            IDLE_RX_HEAVY: return 6;
            IDLE_TX_HEAVY: return 46;
            default:       return 0;
        endcase
    endfunction

    function automatic int receiver_idle_pct();
        case (idle_mode)
            IDLE_RX_HEAVY: return 46;
            IDLE_TX_HEAVY: return 6;
            default:       return 0;
        endcase
    endfunction

    // True when the entry ranks strictly above the held entry in the slot.
    function automatic bit outranks(logic signed [SCORE_BITS-1:0] s,
                                    logic [POSITION_BITS-1:0] p, int slot);
        if (s != held_score[slot]) return s > held_score[slot];
        return p < held_pos[slot];
    endfunction

    // Files one accepted entry into the ranked list; at the row end the best
    // entries are queued as expected results and the list is emptied.
    function automatic void rank_entry(t_in_item e);
        logic signed [SCORE_BITS-1:0] s;
        int        slot;
        int        top;
        int        report;
        t_out_item r;
        s = e.score;
        slot = 0;
        while (slot < held_count && !outranks(s, e.position, slot)) slot++;
        if (slot < KEEP_MAX) begin
            top = (held_count < KEEP_MAX) ? held_count : KEEP_MAX - 1;
            for (int i = top; i > slot; i--) begin
                held_score[i] = held_score[i-1];
                held_pos[i]   = held_pos[i-1];
            end
            held_score[slot] = s;
            held_pos[slot]   = e.position;
            if (held_count < KEEP_MAX) held_count++;
        end
        if (e.row_last) begin
            if (keep_setting == 0) begin
                report = 1;
            end else if (keep_setting > KEEP_MAX) begin
                report = KEEP_MAX;
            end else begin
                report = keep_setting;
            end
            if (held_count < report) report = held_count;
            for (int i = 0; i < report; i++) begin
                r.best_position = held_pos[i];
                r.top_score     = held_score[i];
                r.run_last      = (i == report - 1);
                pending_best = {pending_best, r};
            end
            held_count = 0;
            rows_closed++;
        end
    endfunction

    function automatic void push_entry(logic signed [SCORE_BITS-1:0] s,
                                       logic [POSITION_BITS-1:0] p, logic last);
        t_in_item e;
        e.score    = s;
        e.position = p;
        e.row_last = last;
        entry_queue = {entry_queue, e};
        entries_queued++;
    endfunction

    // Short rows covering the field extremes, ties and a full list.
    function automatic void queue_directed();
        push_entry(16'sh8000, 20'h00000, 1'b1);
        push_entry(16'sh7FFF, 20'hFFFFF, 1'b0);
        push_entry(-16'sd1, 20'd1, 1'b0);
        push_entry(16'sd5, 20'd10, 1'b0);
        push_entry(16'sd5, 20'd3, 1'b0);
        push_entry(16'sd5, 20'd3, 1'b0);
        push_entry(16'sh8000, 20'hFFFFF, 1'b1);
        // Descending scores: the seventeenth entry ranks below a full list.
        for (int i = 0; i <= KEEP_MAX; i++) begin
            push_entry(16'(1000 - 10 * i), 20'(i), 1'b0);
        end
        push_entry(16'sd995, 20'd20, 1'b1);
    endfunction

    // Random rows; the phase may end part way through a row so that the
    // keep count changes while entries are held.
    function automatic void queue_phase(int count, bit leave_open);
        int                           row_left;
        t_score_style                 score_style;
        t_pos_style                   pos_style;
        logic signed [SCORE_BITS-1:0] s;
        logic [POSITION_BITS-1:0]     p;
        logic                         last;
        row_left    = 0;
        score_style = SCORE_WIDE;
        pos_style   = POS_WIDE;
        for (int n = 0; n < count; n++) begin
            if (row_left == 0) begin
                row_left = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 40)
                                                       : $urandom_range(1, 20);
                score_style = t_score_style'($urandom_range(0, 3));
                pos_style   = t_pos_style'($urandom_range(0, 2));
            end
            row_left--;
            case (score_style)
                SCORE_NARROW: s = 16'($urandom_range(0, 3));
                SCORE_EXTREME: begin
                    case ($urandom_range(0, 3))
                        0:       s = 16'sh8000;
                        1:       s = 16'sh7FFF;
                        2:       s = '0;
                        default: s = '1;
                    endcase
                end
                SCORE_MIXED: s = $urandom_range(0, 1) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 3));
                default: s = 16'($urandom);
            endcase
            case (pos_style)
                POS_NARROW: p = 20'($urandom_range(0, 7));
                POS_HIGH:   p = 20'hFFFFF - 20'($urandom_range(0, 3));
                default:    p = 20'($urandom);
            endcase
            last = (row_left == 0);
            if (n == count - 1) last = !leave_open;
            push_entry(s, p, last);
        end
    endfunction

    task automatic drain();
        while (entries_accepted != entries_queued || pending_best.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Driver: offers queued entries and records each accepted transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                rank_entry(i_in_data);
                entries_accepted++;
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (entry_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
                    i_in_data  <= entry_queue.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transfer and drives the receiver stall.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_best.size() == 0) begin
                    $display("%0t: unexpected result, position %0h score %0d last %0b",
                             $time, o_out_data.best_position, o_out_data.top_score,
                             o_out_data.run_last);
                    errors++;
                end else begin
                    want = pending_best.pop_front();
                    if (o_out_data.best_position !== want.best_position) begin
                        $display("%0t: best_position expected %0h, got %0h",
                                 $time, want.best_position, o_out_data.best_position);
                        errors++;
                    end
                    if (o_out_data.top_score !== want.top_score) begin
                        $display("%0t: top_score expected %0d, got %0d",
                                 $time, want.top_score, o_out_data.top_score);
                        errors++;
                    end
                    if (o_out_data.run_last !== want.run_last) begin
                        $display("%0t: run_last expected %0b, got %0b",
                                 $time, want.run_last, o_out_data.run_last);
                        errors++;
                    end
                    results_checked++;
                end
            end
            // A long hold-off fills the block while entries keep coming.
            if (squeeze_left != 0) begin
                squeeze_left--;
                i_out_stall <= 1'b1;
            end else if (squeeze_armed && !squeeze_done) begin
                squeeze_left = SQUEEZE_CYCLES - 1;
                squeeze_done = 1'b1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < receiver_idle_pct());
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, pending_best.size());
                $display("FAIL segment_top_k_selector");
                $finish;
            end
        end
    end

    // Sequence of phases, each with a keep count and an idling pattern.
    initial begin
        logic [KEEP_BITS-1:0] keep_plan [PHASE_COUNT];
        keep_plan[0] = 5'd16;
        keep_plan[1] = 5'd0;
        keep_plan[2] = 5'd31;
        keep_plan[3] = 5'd1;
        keep_plan[4] = 5'd17;
        keep_plan[5] = 5'($urandom_range(2, 15));
        keep_plan[6] = 5'($urandom_range(0, 31));
        keep_plan[7] = 5'd8;
        keep_plan[8] = 5'($urandom_range(1, 16));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        queue_directed();
        drain();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_data <= keep_plan[p];
            @(posedge i_clk);
            i_cfg_we     <= 1'b0;
            keep_setting = keep_plan[p];
            @(negedge i_clk);
            if (p < 3) begin
                idle_mode = IDLE_RX_HEAVY;
            end else if (p < 6) begin
                idle_mode = IDLE_TX_HEAVY;
            end else begin
                idle_mode = IDLE_NONE;
            end
            if (p == 4) squeeze_armed = 1'b1;
            queue_phase(PHASE_ITEMS, (p != PHASE_COUNT - 1) && ($urandom_range(0, 1) == 1));
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Ranked %0d entries over %0d closed rows and checked %0d reported entries,",
                 entries_accepted, rows_closed, results_checked);
        $display("with keep counts from 0 to 31 and a long receiver hold-off.");
        if (errors == 0) begin
            $display("PASS segment_top_k_selector");
        end else begin
            $display("FAIL segment_top_k_selector");
        end
        $finish;
    end

endmodule
